FILE: rtl/rfc822_message_byte_parser_defines.svh
// assertion macros used by rfc_back
`ifndef RFC822_MESSAGE_BYTE_PARSER_DEFINES_SVH
`define RFC822_MESSAGE_BYTE_PARSER_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RFC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// implication checked in the cycle after the antecedent
`define RFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/rfc_pkg.sv
package rfc_pkg;

   localparam int RFC_QUEUE_DEPTH = 2;

   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_DEL   = 8'h7F;

   typedef enum logic [3:0] {
      ST_LINE_START = 4'd0,
      ST_NAME       = 4'd1,
      ST_VAL        = 4'd2,
      ST_VAL_CR     = 4'd3,
      ST_VAL_CRLF   = 4'd4,
      ST_FOLD       = 4'd5,
      ST_BLANK_CR   = 4'd6,
      ST_BODY       = 4'd7,
      ST_MSG_CR     = 4'd8,
      ST_BAD_INPUT  = 4'd9
   } parse_state_type;

   typedef enum logic [3:0] {
      EV_NAME         = 4'd0,
      EV_NAME_END     = 4'd1,
      EV_VALUE        = 4'd2,
      EV_FOLD         = 4'd3,
      EV_VALUE_END    = 4'd4,
      EV_WAIT         = 4'd5,
      EV_BODY_START   = 4'd6,
      EV_BODY         = 4'd7,
      EV_UNEXPECTED   = 4'd8,
      EV_BODY_NEWLINE = 4'd9,
      EV_BODY_CR      = 4'd10
   } ev_kind_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [1:0]  count;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
   } event_type;

   // everything one input byte causes
   typedef struct packed {
      logic      two;
      event_type ev0;
      event_type ev1;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } q_head_type;

   typedef struct packed {
      parse_state_type next;
      job_type         job;
   } classify_type;

   function automatic event_type mk_event(ev_kind_type kind, logic [1:0] count,
                                          logic [7:0] b0, logic [7:0] b1);
      event_type e;
      e.kind  = kind;
      e.count = count;
      e.byte0 = (count != 2'd0) ? b0 : 8'd0;
      e.byte1 = (count == 2'd2) ? b1 : 8'd0;
      return e;
   endfunction

   function automatic classify_type classify(parse_state_type s, logic [7:0] c);
      classify_type r;
      logic         ctl;
      logic         plain;
      logic         lwsp;
      ctl   = (c < 8'd32) || (c == CH_DEL);
      plain = ~c[7];
      lwsp  = (c == CH_SPACE) || (c == CH_TAB);
      r.next    = ST_BAD_INPUT;
      r.job.two = 1'b0;
      r.job.ev0 = mk_event(EV_UNEXPECTED, 2'd1, c, 8'd0);
      r.job.ev1 = mk_event(EV_UNEXPECTED, 2'd0, 8'd0, 8'd0);
      unique case (s)
         ST_LINE_START, ST_NAME: begin
            if (c == CH_COLON) begin
               if (s == ST_NAME) begin
                  r.job.ev0 = mk_event(EV_NAME_END, 2'd1, CH_COLON, 8'd0);
                  r.next    = ST_VAL;
               end
            end else if (!((c == CH_SPACE) || ctl || !plain)) begin
               r.job.ev0 = mk_event(EV_NAME, 2'd1, c, 8'd0);
               r.next    = ST_NAME;
            end
         end
         ST_VAL: begin
            if (lwsp) begin
               r.job.ev0 = mk_event(EV_FOLD, 2'd1, c, 8'd0);
               r.next    = ST_FOLD;
            end else if (c == CH_CR) begin
               r.job.ev0 = mk_event(EV_WAIT, 2'd0, 8'd0, 8'd0);
               r.next    = ST_VAL_CR;
            end else begin
               r.job.ev0 = mk_event(EV_VALUE, 2'd1, c, 8'd0);
               r.next    = ST_VAL;
            end
         end
         ST_VAL_CR: begin
            if (c == CH_LF) begin
               r.job.ev0 = mk_event(EV_WAIT, 2'd0, 8'd0, 8'd0);
               r.next    = ST_VAL_CRLF;
            end else begin
               // lone cr in a value is handed back before the byte
               r.job.two = 1'b1;
               r.job.ev0 = mk_event(EV_VALUE, 2'd1, CH_CR, 8'd0);
               r.job.ev1 = mk_event(EV_VALUE, 2'd1, c, 8'd0);
               r.next    = ST_VAL;
            end
         end
         ST_VAL_CRLF: begin
            priority if (c == CH_COLON) begin
               r.next = ST_BAD_INPUT;
            end else if (c == CH_CR) begin
               r.job.ev0 = mk_event(EV_WAIT, 2'd0, 8'd0, 8'd0);
               r.next    = ST_BLANK_CR;
            end else if (lwsp) begin
               r.job.two = 1'b1;
               r.job.ev0 = mk_event(EV_FOLD, 2'd2, CH_CR, CH_LF);
               r.job.ev1 = mk_event(EV_FOLD, 2'd1, c, 8'd0);
               r.next    = ST_FOLD;
            end else if (ctl) begin
               r.job.two = 1'b1;
               r.job.ev0 = mk_event(EV_VALUE_END, 2'd2, CH_CR, CH_LF);
               r.job.ev1 = mk_event(EV_UNEXPECTED, 2'd1, c, 8'd0);
               r.next    = ST_BAD_INPUT;
            end else if (plain) begin
               r.job.two = 1'b1;
               r.job.ev0 = mk_event(EV_VALUE_END, 2'd2, CH_CR, CH_LF);
               r.job.ev1 = mk_event(EV_NAME, 2'd1, c, 8'd0);
               r.next    = ST_NAME;
            end else begin
               r.next = ST_BAD_INPUT;
            end
         end
         ST_FOLD: begin
            if (lwsp) begin
               r.job.ev0 = mk_event(EV_FOLD, 2'd1, c, 8'd0);
               r.next    = ST_FOLD;
            end else begin
               r.job.ev0 = mk_event(EV_VALUE, 2'd1, c, 8'd0);
               r.next    = ST_VAL;
            end
         end
         ST_BLANK_CR: begin
            r.job.two = 1'b1;
            r.job.ev0 = mk_event(EV_VALUE_END, 2'd2, CH_CR, CH_LF);
            if (c == CH_LF) begin
               r.job.ev1 = mk_event(EV_BODY_START, 2'd2, CH_CR, CH_LF);
               r.next    = ST_BODY;
            end else begin
               r.job.ev1 = mk_event(EV_UNEXPECTED, 2'd1, c, 8'd0);
               r.next    = ST_BAD_INPUT;
            end
         end
         ST_BODY: begin
            if (c == CH_CR) begin
               r.job.ev0 = mk_event(EV_BODY_CR, 2'd1, c, 8'd0);
               r.next    = ST_MSG_CR;
            end else begin
               r.job.ev0 = mk_event(EV_BODY, 2'd1, c, 8'd0);
               r.next    = ST_BODY;
            end
         end
         ST_MSG_CR: begin
            if (c == CH_LF) begin
               r.job.ev0 = mk_event(EV_BODY_NEWLINE, 2'd1, c, 8'd0);
               r.next    = ST_BODY;
            end
         end
         default: begin
            r.next = ST_BAD_INPUT;
         end
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/rfc822_message_byte_parser.sv
// channel | dir | handshake                | payload
// req     | in  | req_tvalid / req_tready  | tdata[7:0] in_byte
// rsp     | out | rsp_tvalid / rsp_tready  | tuser event_kind, tdata counts and bytes, tlast
//
// one event leaves per cycle while rsp_tready is high; a byte giving two events
// loads the output register twice, first with its first event, then its second
// sustained byte rate is limited by the single output register
// reset clears the parse state to name start, empties the queue, drops rsp_tvalid
// input stalls only when the job queue (QUEUE_DEPTH bytes) is full
// first event of a byte passes through the job queue, then the output register
module rfc822_message_byte_parser #(
   parameter int QUEUE_DEPTH = rfc_pkg::RFC_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // byte_count, first_byte, second_byte, zero pad
   output logic        rsp_tlast,
   output logic [3:0]  rsp_tuser   // event_kind
);
   import rfc_pkg::*;

   logic       q_full;
   logic       push;
   job_type    push_job;
   logic       pop;
   q_head_type head;

   rfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   rfc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .head     (head)
   );

   rfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: rtl/rfc_front.sv
module rfc_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,
   input  logic             q_full,
   output logic             push,
   output rfc_pkg::job_type push_job
);
   import rfc_pkg::*;

   parse_state_type state_ff;
   parse_state_type state_in;
   classify_type    cls;

   always_comb begin
      cls = classify(state_ff, req_tdata);
   end

   always_comb begin
      state_in = push ? cls.next : state_ff;
   end

   always_comb begin
      req_tready = ~q_full;
      push       = req_tvalid & ~q_full;
      push_job   = cls.job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LINE_START;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/rfc_queue.sv
module rfc_queue #(
   parameter int DEPTH = rfc_pkg::RFC_QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  rfc_pkg::job_type    push_job,
   input  logic                pop,
   output logic                full,
   output rfc_pkg::q_head_type head
);
   import rfc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             do_pop;

   always_comb begin
      full       = (count_ff == CNT_FULL);
      head.valid = (count_ff != '0);
      head.job   = entry_ff[rd_ptr_ff];
      do_pop     = pop & head.valid;
      wr_ptr_in  = push ? ((wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? ((rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/rfc_back.sv
`include "rfc822_message_byte_parser_defines.svh"

module rfc_back (
   input  logic                clock,
   input  logic                reset,
   input  rfc_pkg::q_head_type head,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic [3:0]          rsp_tuser
);
   import rfc_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   logic      phase_ff;
   logic      phase_in;
   event_type ev_ff;
   event_type ev_in;
   logic      last_ff;
   logic      last_in;
   logic      load;

   always_comb begin
      load     = head.valid & (~valid_ff | rsp_tready);
      pop      = load & (phase_ff | ~head.job.two);
      phase_in = load ? (~phase_ff & head.job.two) : phase_ff;
      valid_in = load | (valid_ff & ~rsp_tready);
      ev_in    = phase_ff ? head.job.ev1 : head.job.ev0;
      last_in  = phase_ff | ~head.job.two;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         ev_ff   <= ev_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

   // tdata: byte_count, first_byte, second_byte, zero pad
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {6'd0, ev_ff.byte1, ev_ff.byte0, ev_ff.count};
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = ev_ff.kind;

   `RFC_ASSERT_IMPLY(a_second_pending, clock, reset, phase_ff, head.valid && head.job.two)
   `RFC_ASSERT_NEXT(a_second_follows, clock, reset, valid_ff && rsp_tready && !last_ff, valid_ff)
   `RFC_ASSERT_IMPLY(a_wait_empty, clock, reset, valid_ff && ev_ff.count == 2'd0, ev_ff.kind == EV_WAIT)

endmodule
